// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cflba_pkg.sv =====
// Types and constants of the chunked free-list block allocator
`timescale 1ns / 1ps
`default_nettype none

package cflba_pkg;

  localparam int TYPE_W = 2;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;

  localparam logic [CNT_W-1:0] COUNT_MAX     = 11'd2047;
  localparam logic [CNT_W-1:0] CHUNK_DEFAULT = 11'd16;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REFILL,
    ST_RELOAD
  } state_t;

  typedef enum logic {
    STATUS_OK        = 1'b0,
    STATUS_EXHAUSTED = 1'b1
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cflba_ifs.sv =====
// Request and response channel interfaces of the allocator
`timescale 1ns / 1ps
`default_nettype none

interface cflba_req_if;
  logic                         valid;
  logic                         ready;
  logic [cflba_pkg::TYPE_W-1:0] req_type;
  logic [cflba_pkg::IDX_W-1:0]  free_index;

  modport source (output valid, req_type, free_index, input ready);
  modport sink (input valid, req_type, free_index, output ready);
endinterface

interface cflba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [cflba_pkg::IDX_W-1:0] block_index;
  logic                        status;
  logic [cflba_pkg::CNT_W-1:0] available_count;

  modport source (output valid, block_index, status, available_count, input ready);
  modport sink (input valid, block_index, status, available_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cflba_link_mem.sv =====
// Link memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module cflba_link_mem #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [$clog2(DEPTH)-1:0] rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [$clog2(DEPTH)-1:0] wr_data
);

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cflba_ctrl.sv =====
// Allocator sequencer: list head, counters, refill walk and result register
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cflba_ctrl #(
  parameter int POOL_BLOCKS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  cflba_req_if.sink                           req,
  cflba_rsp_if.source                         rsp,
  input  wire logic [$clog2(POOL_BLOCKS)-1:0] req_index,
  input  wire logic [cflba_pkg::CNT_W-1:0]    chunk,
  output logic      [$clog2(POOL_BLOCKS)-1:0] mem_rd_addr,
  input  wire logic [$clog2(POOL_BLOCKS)-1:0] mem_rd_data,
  output logic                                mem_wr_en,
  output logic      [$clog2(POOL_BLOCKS)-1:0] mem_wr_addr,
  output logic      [$clog2(POOL_BLOCKS)-1:0] mem_wr_data
);

  localparam int AW = $clog2(POOL_BLOCKS);
  localparam int WW = $clog2(POOL_BLOCKS + 1);
  localparam int CW = cflba_pkg::CNT_W;
  localparam int LW = ((WW > CW) ? WW : CW) + 1;
  localparam int XW = (AW > cflba_pkg::IDX_W) ? AW : cflba_pkg::IDX_W;

  cflba_pkg::state_t state, state_next;

  logic [cflba_pkg::TYPE_W-1:0] req_type_q, req_type_q_next;
  logic [AW-1:0]                index_q, index_q_next;
  logic [AW-1:0]                head, head_next;
  logic                         nonempty, nonempty_next;
  logic [WW-1:0]                watermark, watermark_next;
  logic [CW-1:0]                count, count_next;
  logic [CW-1:0]                fill, fill_next;

  logic                         out_valid, out_valid_next;
  logic [cflba_pkg::IDX_W-1:0]  out_block, out_block_next;
  logic                         out_status, out_status_next;
  logic [CW-1:0]                out_count, out_count_next;

  logic          out_free;
  logic          chunk_ok;
  logic [LW-1:0] fill_addr;
  logic [LW-1:0] chunk_end;
  logic [XW-1:0] head_wide;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] count_inc;

  assign out_free  = !out_valid || rsp.ready;
  assign chunk_ok  = (chunk != '0) &&
                     (LW'(chunk) <= (LW'(POOL_BLOCKS) - LW'(watermark)));
  assign fill_addr = LW'(watermark) + LW'(fill);
  assign chunk_end = LW'(watermark) + LW'(chunk);
  assign head_wide = XW'(head);
  assign count_dec = (count != '0) ? (count - 1'b1) : '0;
  assign count_inc = (count == cflba_pkg::COUNT_MAX) ? count : (count + 1'b1);

  assign mem_rd_addr = head;

  assign req.ready           = (state == cflba_pkg::ST_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.block_index     = out_block;
  assign rsp.status          = out_status;
  assign rsp.available_count = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cflba_pkg::ST_IDLE;
      head      <= '0;
      nonempty  <= 1'b0;
      watermark <= '0;
      count     <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      nonempty  <= nonempty_next;
      watermark <= watermark_next;
      count     <= count_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_type_q <= req_type_q_next;
    index_q    <= index_q_next;
    out_block  <= out_block_next;
    out_status <= out_status_next;
    out_count  <= out_count_next;
  end

  always_comb begin
    state_next      = state;
    req_type_q_next = req_type_q;
    index_q_next    = index_q;
    head_next       = head;
    nonempty_next   = nonempty;
    watermark_next  = watermark;
    count_next      = count;
    fill_next       = fill;
    out_valid_next  = out_valid && !rsp.ready;
    out_block_next  = out_block;
    out_status_next = out_status;
    out_count_next  = out_count;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = index_q;
    mem_wr_data     = head;

    case (state)
      cflba_pkg::ST_IDLE: begin
        if (req.valid) begin
          req_type_q_next = req.req_type;
          index_q_next    = req_index;
          state_next      = cflba_pkg::ST_EXEC;
        end
      end

      cflba_pkg::ST_EXEC: begin
        if (req_type_q == cflba_pkg::REQ_ALLOC && !nonempty && chunk_ok) begin
          fill_next  = '0;
          state_next = cflba_pkg::ST_REFILL;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_block_next  = '0;
          out_status_next = cflba_pkg::STATUS_OK;
          out_count_next  = count;
          state_next      = cflba_pkg::ST_IDLE;
          if (req_type_q == cflba_pkg::REQ_ALLOC) begin
            if (nonempty) begin
              out_block_next = head_wide[cflba_pkg::IDX_W-1:0];
              out_count_next = count_dec;
              head_next      = mem_rd_data;
              count_next     = count_dec;
              nonempty_next  = (count_dec != '0);
            end else begin
              out_status_next = cflba_pkg::STATUS_EXHAUSTED;
            end
          end else if (req_type_q == cflba_pkg::REQ_FREE) begin
            mem_wr_en      = 1'b1;
            head_next      = index_q;
            nonempty_next  = 1'b1;
            count_next     = count_inc;
            out_count_next = count_inc;
          end
        end
      end

      cflba_pkg::ST_REFILL: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = fill_addr[AW-1:0];
        mem_wr_data = (fill == '0) ? '0 : AW'(fill_addr - 1'b1);
        fill_next   = fill + 1'b1;
        if (fill_next == chunk) begin
          head_next      = AW'(chunk_end - 1'b1);
          nonempty_next  = 1'b1;
          count_next     = chunk;
          watermark_next = chunk_end[WW-1:0];
          state_next     = cflba_pkg::ST_RELOAD;
        end
      end

      cflba_pkg::ST_RELOAD: begin
        state_next = cflba_pkg::ST_EXEC;
      end

      default: begin
        state_next = cflba_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_count_tracks_list, nonempty == (count != '0), "list flag and count disagree")
  `ASSERT_ALWAYS(a_head_in_pool, LW'(head) < LW'(POOL_BLOCKS), "list head outside the pool")
  `ASSERT_ALWAYS(a_watermark_bound, LW'(watermark) <= LW'(POOL_BLOCKS), "watermark past pool end")
  `ASSERT_IMPLIES(a_refill_bound, state == cflba_pkg::ST_REFILL, fill < chunk, "refill overran chunk")

endmodule

`default_nettype wire

// ===== hw/rtl/chunked_free_list_block_allocator.sv =====
// Top level of the chunked free-list block allocator
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Payload
// req      in   valid/ready    req_type, free_index
// rsp      out  valid/ready    block_index, status, available_count
// cfg      in   cfg_wr_en      cfg_wr_data (blocks_per_chunk)
//
// Allocate, free and query each pass through the idle and execute states; an
// allocate reads one link and a free writes one. An allocate on an empty list
// first threads blocks_per_chunk blocks, one link write a cycle, then reloads.
// Reset is synchronous; no clearing pass, the link memory is not initialised.
// A result waits in an output register; the next item is taken meanwhile,
// and the sequencer holds only when a second result finds that register full.

module chunked_free_list_block_allocator #(
  parameter int POOL_BLOCKS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  cflba_req_if.sink                        req,
  cflba_rsp_if.source                      rsp,
  input  wire logic                        cfg_wr_en,
  input  wire logic [cflba_pkg::CNT_W-1:0] cfg_wr_data
);

  localparam int AW    = $clog2(POOL_BLOCKS);
  localparam int IW    = cflba_pkg::IDX_W;
  localparam int XW    = ((AW > IW) ? AW : IW) + 1;
  localparam int NSTEP = $clog2(((2 ** IW) - 1) / POOL_BLOCKS + 1);

  logic [cflba_pkg::CNT_W-1:0] chunk;
  logic [AW-1:0]               req_index;
  logic [XW-1:0]               reduce;
  logic [AW-1:0]               mem_rd_addr;
  logic [AW-1:0]               mem_rd_data;
  logic                        mem_wr_en;
  logic [AW-1:0]               mem_wr_addr;
  logic [AW-1:0]               mem_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= cflba_pkg::CHUNK_DEFAULT;
    end else if (cfg_wr_en) begin
      chunk <= cfg_wr_data;
    end
  end

  // fold the index into the pool by restoring subtraction of shifted pool sizes
  always_comb begin
    reduce = XW'(req.free_index);
    for (int k = NSTEP - 1; k >= 0; k--) begin
      if (reduce >= (XW'(POOL_BLOCKS) << k)) begin
        reduce = reduce - (XW'(POOL_BLOCKS) << k);
      end
    end
    req_index = reduce[AW-1:0];
  end

  cflba_link_mem #(
    .DEPTH (POOL_BLOCKS)
  ) u_link_mem (
    .clk     (clk),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  cflba_ctrl #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .req_index   (req_index),
    .chunk       (chunk),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

endmodule

`default_nettype wire
